// ----- rtl/core/uer_pkg.sv -----
// uer_pkg: shared constants for the ultrasonic echo ranger.
// No dependencies; used by the result and configuration channel interfaces and the top level.
package uer_pkg;

    localparam int TIMEOUT_W   = 20;
    localparam int ELAPSED_W   = 21;
    localparam int PULSE_W     = 20;
    localparam int DIST_W      = 21;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(23529);
    localparam int                   TRIGGER_TICKS_DEF = 10;

    // floor(p * 17 / 10) == (p * DIST_MUL) >> DIST_SHIFT for every 20-bit p
    // DIST_MUL = 17 * ceil(2^28 / 10)
    localparam int                DIST_SHIFT = 28;
    localparam int                DIST_MUL_W = 29;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(456340282);
    localparam int                PROD_W     = PULSE_W + DIST_MUL_W;

    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRIG = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_HIGH = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

endpackage

// ----- rtl/core/uer_in_if.sv -----
// uer_in_if: input item channel (command, echo level).
// No dependencies.
interface uer_in_if;
    logic valid;
    logic ready;
    logic command;
    logic echo_level;

    modport source (output valid, output command, output echo_level, input ready);
    modport sink   (input valid, input command, input echo_level, output ready);
endinterface

// ----- rtl/core/uer_out_if.sv -----
// uer_out_if: result item channel of the ranger.
// Depends on uer_pkg for field widths.
interface uer_out_if;
    logic                         valid;
    logic                         ready;
    logic                         trigger_level;
    logic                         busy_res;
    logic                         done_res;
    logic                         timed_out;
    logic [uer_pkg::PULSE_W-1:0]  pulse_us;
    logic [uer_pkg::DIST_W-1:0]   distance_hcm;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output timed_out, output pulse_us, output distance_hcm, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input timed_out, input pulse_us, input distance_hcm, output ready);
endinterface

// ----- rtl/core/uer_cfg_if.sv -----
// uer_cfg_if: configuration write channel carrying the timeout value.
// Depends on uer_pkg for the data width.
interface uer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uer_pkg::TIMEOUT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// ultrasonic_echo_ranger: trigger/echo ranging controller, two register stages.
// Depends on uer_pkg, uer_in_if, uer_out_if and uer_cfg_if.
//
// One item per clock unless o_out.ready stalls: each input item (a microsecond
// tick or a start) gives exactly one result item via both stages. The first
// stage updates the ranging state and registers the status and pulse width;
// the second turns the width into distance through one constant multiply into
// the output register. Throughput is limited only by o_out.ready; i_in.ready
// drops only when both stages hold items that the output side has not taken.
// Configuration writes are always accepted and take effect on the next item.
module ultrasonic_echo_ranger #(
    parameter int TRIGGER_TICKS = uer_pkg::TRIGGER_TICKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uer_in_if.sink     i_in,
    uer_cfg_if.sink    i_cfg,
    uer_out_if.source  o_out
);
    import uer_pkg::*;

    localparam int TCNT_W = $clog2(TRIGGER_TICKS + 1);

    logic [TIMEOUT_W-1:0] r_timeout_us;
    logic [PHASE_W-1:0]   r_phase,   n_phase;
    logic [TCNT_W-1:0]    r_trig_cnt, n_trig_cnt;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [PULSE_W-1:0]   r_width,   n_width;

    logic                 n_done, n_tmo;
    logic [PULSE_W-1:0]   n_pulse;

    logic                 r_s1_valid;
    logic                 r_s1_trig, r_s1_busy, r_s1_done, r_s1_tmo;
    logic [PULSE_W-1:0]   r_s1_pulse;

    logic                 r_out_valid;
    logic                 r_out_trig, r_out_busy, r_out_done, r_out_tmo;
    logic [PULSE_W-1:0]   r_out_pulse;
    logic [DIST_W-1:0]    r_out_dist;

    logic                 out_adv, s1_adv, in_fire;
    logic [PROD_W-1:0]    dist_prod;

    assign out_adv  = !r_out_valid || o_out.ready;
    assign s1_adv   = !r_s1_valid || out_adv;
    assign i_in.ready = s1_adv;
    assign in_fire  = i_in.valid && s1_adv;
    assign i_cfg.ready = 1'b1;

    // ranging state update for one item
    always_comb begin
        n_phase    = r_phase;
        n_trig_cnt = r_trig_cnt;
        n_elapsed  = r_elapsed;
        n_width    = r_width;
        n_done     = 1'b0;
        n_tmo      = 1'b0;
        n_pulse    = '0;
        if (i_in.command == CMD_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase    = PH_TRIG;
                n_trig_cnt = '0;
            end
        end else begin
            unique case (r_phase) inside
                PH_TRIG: begin
                    n_trig_cnt = r_trig_cnt + 1'b1;
                    if (n_trig_cnt >= TCNT_W'(TRIGGER_TICKS)) begin
                        n_phase   = PH_WAIT;
                        n_elapsed = '0;
                        n_width   = '0;
                    end
                end
                PH_WAIT, PH_HIGH: begin
                    if (r_phase == PH_HIGH && !i_in.echo_level) begin
                        n_done  = 1'b1;
                        n_pulse = r_width;
                        n_phase = PH_IDLE;
                    end else begin
                        n_elapsed = r_elapsed + 1'b1;
                        if (i_in.echo_level) begin
                            n_width = r_width + 1'b1;
                            n_phase = PH_HIGH;
                        end
                        if (n_elapsed > ELAPSED_W'(r_timeout_us)) begin
                            n_done  = 1'b1;
                            n_tmo   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign dist_prod = PROD_W'(r_s1_pulse) * PROD_W'(DIST_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us <= TIMEOUT_RST;
            r_phase      <= PH_IDLE;
            r_trig_cnt   <= '0;
            r_elapsed    <= '0;
            r_width      <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_timeout_us <= i_cfg.data;
            end
            if (in_fire) begin
                r_phase    <= n_phase;
                r_trig_cnt <= n_trig_cnt;
                r_elapsed  <= n_elapsed;
                r_width    <= n_width;
            end
            if (s1_adv) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_trig  <= (n_phase == PH_TRIG);
            r_s1_busy  <= (n_phase != PH_IDLE);
            r_s1_done  <= n_done;
            r_s1_tmo   <= n_tmo;
            r_s1_pulse <= n_pulse;
        end
        if (out_adv && r_s1_valid) begin
            r_out_trig  <= r_s1_trig;
            r_out_busy  <= r_s1_busy;
            r_out_done  <= r_s1_done;
            r_out_tmo   <= r_s1_tmo;
            r_out_pulse <= r_s1_pulse;
            r_out_dist  <= dist_prod[DIST_SHIFT +: DIST_W];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.trigger_level = r_out_trig;
    assign o_out.busy_res      = r_out_busy;
    assign o_out.done_res      = r_out_done;
    assign o_out.timed_out     = r_out_tmo;
    assign o_out.pulse_us      = r_out_pulse;
    assign o_out.distance_hcm  = r_out_dist;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> !o_out.busy_res && !o_out.trigger_level)
        else $error("finished item still reports busy");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.trigger_level |-> o_out.busy_res)
        else $error("trigger high while idle");

    a_tmo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.timed_out |->
            o_out.done_res && o_out.pulse_us == '0 && o_out.distance_hcm == '0)
        else $error("timed-out item carries a measurement");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_adv |=> r_s1_valid && $stable(r_s1_pulse))
        else $error("stage one item lost under stall");

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for ultrasonic_echo_ranger.
// Drives tick/start items and timeout writes, predicts each result item and
// checks it field by field. Depends on uer_pkg and the uer_*_if interfaces.
module tb_top;
    import uer_pkg::*;

    localparam int          TRIG_TICKS  = TRIGGER_TICKS_DEF;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 35;
    localparam int unsigned DIST_NUM    = 17;
    localparam int unsigned DIST_DEN    = 10;

    typedef enum logic {OP_ITEM, OP_CFG} t_op_kind;

    typedef struct {
        t_op_kind               kind;
        logic                   cmd;
        logic                   echo;
        logic [TIMEOUT_W-1:0]   value;
    } t_stim_op;

    typedef struct packed {
        logic                   trigger;
        logic                   busy;
        logic                   done;
        logic                   timed_out;
        logic [PULSE_W-1:0]     pulse;
        logic [DIST_W-1:0]      dist_hcm;
    } t_echo_result;

    logic clk = 1'b0;
    logic rst_n;

    uer_in_if  in_ch ();
    uer_cfg_if cfg_ch ();
    uer_out_if out_ch ();

    ultrasonic_echo_ranger dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ranging state as the block should hold it
    logic [PHASE_W-1:0]     pr_phase;
    logic [9:0]             pr_trig_cnt;
    logic [ELAPSED_W-1:0]   pr_elapsed;
    logic [PULSE_W-1:0]     pr_width;
    logic [TIMEOUT_W-1:0]   pr_timeout;

    t_stim_op       pending_ops[$];
    t_echo_result   expected_res[$];

    int unsigned n_planned, n_in, n_out, n_done, n_tmo, n_cfg, n_err;
    int unsigned idle_cycles, send_gap, hold_left;
    bit          steady_in, steady_out, long_hold_done;

    function automatic t_echo_result ranger_step(logic cmd, logic echo);
        t_echo_result       r;
        logic [PULSE_W-1:0] pulse;
        logic               fin;
        logic               tmo;
        fin   = 1'b0;
        tmo   = 1'b0;
        pulse = '0;
        if (cmd == CMD_START) begin
            if (pr_phase == PH_IDLE) begin
                pr_phase    = PH_TRIG;
                pr_trig_cnt = '0;
            end
        end else if (pr_phase == PH_TRIG) begin
            pr_trig_cnt = pr_trig_cnt + 1'b1;
            if (pr_trig_cnt >= TRIG_TICKS) begin
                pr_phase   = PH_WAIT;
                pr_elapsed = '0;
                pr_width   = '0;
            end
        end else if (pr_phase != PH_IDLE) begin
            if (pr_phase == PH_HIGH && !echo) begin
                fin      = 1'b1;
                pulse    = pr_width;
                pr_phase = PH_IDLE;
            end else begin
                pr_elapsed = pr_elapsed + 1'b1;
                if (echo) begin
                    pr_width = pr_width + 1'b1;
                    pr_phase = PH_HIGH;
                end
                if (pr_elapsed > pr_timeout) begin
                    fin      = 1'b1;
                    tmo      = 1'b1;
                    pulse    = '0;
                    pr_phase = PH_IDLE;
                end
            end
        end
        r.trigger   = (pr_phase == PH_TRIG);
        r.busy      = (pr_phase != PH_IDLE);
        r.done      = fin;
        r.timed_out = tmo;
        r.pulse     = pulse;
        r.dist_hcm  = DIST_W'((64'(pulse) * DIST_NUM) / DIST_DEN);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic void push_item(logic cmd, logic echo);
        t_stim_op op;
        op.kind  = OP_ITEM;
        op.cmd   = cmd;
        op.echo  = echo;
        op.value = '0;
        pending_ops.push_back(op);
        n_planned++;
    endfunction

    function automatic void push_cfg(int unsigned value);
        t_stim_op op;
        op.kind  = OP_CFG;
        op.cmd   = CMD_TICK;
        op.echo  = 1'b0;
        op.value = TIMEOUT_W'(value);
        pending_ops.push_back(op);
    endfunction

    // start (optionally a second one), trigger ticks, echo-low wait, echo-high pulse, falling edge
    function automatic void push_measure(int unsigned n_wait, int unsigned n_high,
                                         bit extra_start);
        bit early;
        early = 1'($urandom_range(0, 1));
        push_item(CMD_START, 1'($urandom_range(0, 1)));
        if (extra_start && early)
            push_item(CMD_START, 1'($urandom_range(0, 1)));
        repeat (TRIG_TICKS) push_item(CMD_TICK, 1'($urandom_range(0, 1)));
        if (extra_start && !early)
            push_item(CMD_START, 1'($urandom_range(0, 1)));
        repeat (n_wait) push_item(CMD_TICK, 1'b0);
        repeat (n_high) push_item(CMD_TICK, 1'b1);
        push_item(CMD_TICK, 1'b0);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // sender: items and timeout writes from pending_ops
    always @(posedge clk) begin
        t_echo_result res;
        t_stim_op     op;
        if (!rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.command    <= CMD_TICK;
            in_ch.echo_level <= 1'b0;
            cfg_ch.valid     <= 1'b0;
            cfg_ch.data      <= '0;
            send_gap         = 0;
            pr_phase         = PH_IDLE;
            pr_trig_cnt      = '0;
            pr_elapsed       = '0;
            pr_width         = '0;
            pr_timeout       = TIMEOUT_RST;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                res = ranger_step(in_ch.command, in_ch.echo_level);
                expected_res.push_back(res);
                n_in++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                pr_timeout = cfg_ch.data;
                n_cfg++;
            end
            if ((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
                // still on offer
            end else if (pending_ops.size() != 0 && pending_ops[0].kind == OP_CFG) begin
                in_ch.valid <= 1'b0;
                if (expected_res.size() == 0) begin
                    op = pending_ops.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.data  <= op.value;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end else if (send_gap == 0 && pending_ops.size() != 0) begin
                op = pending_ops.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.command    <= op.cmd;
                in_ch.echo_level <= op.echo;
                cfg_ch.valid     <= 1'b0;
                if ($urandom_range(0, 31) == 0)
                    steady_in = !steady_in;
                send_gap = steady_in ? 0 : pick_gap();
            end else begin
                in_ch.valid  <= 1'b0;
                cfg_ch.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // receiver back-pressure, with one long hold-off mid run
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    = 0;
        end else begin
            if (hold_left == 0 && !long_hold_done && n_in >= 150) begin
                hold_left      = 80;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && !steady_out) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
            if ($urandom_range(0, 47) == 0)
                steady_out = !steady_out;
        end
    end

    // result checker and stall counter
    always @(posedge clk) begin
        t_echo_result want;
        if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            n_out++;
            if (expected_res.size() == 0) begin
                n_err++;
                $display("%0t: result item with nothing expected", $time);
            end else begin
                want = expected_res.pop_front();
                if (want.done)
                    n_done++;
                if (want.timed_out)
                    n_tmo++;
                check_field("trigger_level", 32'(want.trigger), 32'(out_ch.trigger_level));
                check_field("busy_res", 32'(want.busy), 32'(out_ch.busy_res));
                check_field("done_res", 32'(want.done), 32'(out_ch.done_res));
                check_field("timed_out", 32'(want.timed_out), 32'(out_ch.timed_out));
                check_field("pulse_us", 32'(want.pulse), 32'(out_ch.pulse_us));
                check_field("distance_hcm", 32'(want.dist_hcm), 32'(out_ch.distance_hcm));
            end
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned tmo_plan[$];
        int unsigned phase_end;
        int unsigned sel;
        int unsigned n_high;

        rst_n = 1'b0;

        // directed: idle tick, a short pulse on the reset timeout with a
        // start while busy, then a zero timeout
        push_item(CMD_TICK, 1'b1);
        push_measure(1, 2, 1'b1);
        push_cfg(0);
        push_measure(0, 0, 1'b0);

        tmo_plan = '{1, 4, $urandom_range(2, 30), 7, 20'hFFFFF, TIMEOUT_RST, 0,
                     $urandom_range(0, 20'hFFFFF)};
        foreach (tmo_plan[p]) begin
            push_cfg(tmo_plan[p]);
            phase_end = n_planned + PHASE_ITEMS;
            while (n_planned < phase_end) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    n_high = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                         : $urandom_range(1, 8);
                    push_measure($urandom_range(0, 4), n_high, $urandom_range(0, 5) == 0);
                end else if (sel == 7 && tmo_plan[p] <= 40) begin
                    // no echo at all: runs into the timeout
                    push_measure(tmo_plan[p] + 2, 0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            // back to idle before the next write
            repeat (TRIG_TICKS) push_item(CMD_TICK, 1'b0);
            push_item(CMD_TICK, 1'b1);
            push_item(CMD_TICK, 1'b0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_ch.valid || cfg_ch.valid ||
               expected_res.size() != 0);
        repeat (10) @(posedge clk);

        $display("summary: %0d items sent, %0d results checked, %0d timeout writes",
                 n_in, n_out, n_cfg);
        $display("summary: %0d measurements finished, %0d of them timed out, %0d errors",
                 n_done, n_tmo, n_err);
        if (n_err == 0 && expected_res.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
